>>> hw/rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by every module of the block; no dependencies.
package uer_pkg;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_LEAVE   = 2'd1,
    PH_ARRIVE  = 2'd2,
    PH_MEASURE = 2'd3
  } phase_t;

  localparam logic [1:0] CFG_ACTIVE_LEVEL  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_TRIGGER_TICKS = 2'd2;

  localparam logic        RST_ACTIVE_LEVEL  = 1'b1;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd4500;
  localparam logic [15:0] RST_TRIGGER_TICKS = 16'd72;

  typedef struct packed {
    logic        active_level;
    logic [15:0] timeout_ticks;
    logic [15:0] trigger_ticks;
  } cfg_t;

  typedef struct packed {
    logic trig;
    logic done;
    logic tout;
  } tick_flags_t;

  // (count*10+16) at or above 72*2^18 saturates pulse_us
  localparam int          X_SAT_W  = 25;
  localparam logic [24:0] X_SAT    = 25'd18874368;
  localparam int          MUL_TEN  = 10;
  localparam int          ADD_ROUND = 16;

  // floor(2^32/9) and floor(2^32/125)
  localparam logic [28:0] RECIP9   = 29'd477218588;
  localparam logic [25:0] RECIP125 = 26'd34359738;
  localparam logic [4:0]  DIV9     = 5'd9;
  localparam logic [7:0]  DIV125   = 8'd125;
  localparam logic [4:0]  MUL17    = 5'd17;

  localparam logic [17:0] US_MAX = 18'h3FFFF;
  localparam logic [11:0] CM_MAX = 12'hFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

endpackage

>>> hw/rtl/uer_front.sv
// Front end: phase sequencer that classifies each echo tick.
// Depends on uer_pkg; feeds the queue toward uer_back.
module uer_front #(
  parameter int PULSE_COUNT_BITS = 20,
  parameter int WAIT_COUNT_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uer_pkg::cfg_t               cfg,
  input  logic                        fire,
  input  logic                        echo,
  output uer_pkg::tick_flags_t        flags,
  output logic [PULSE_COUNT_BITS-1:0] cnt
);
  import uer_pkg::*;

  localparam int CW = (WAIT_COUNT_BITS > 16) ? WAIT_COUNT_BITS : 16;

  phase_t                      phase_r, phase_nxt;
  logic [WAIT_COUNT_BITS-1:0]  ticks_r, ticks_nxt;
  logic [PULSE_COUNT_BITS-1:0] pulse_r, pulse_nxt;

  logic [CW-1:0]               wmax, to_ext, tr_ext, lim_to, lim_tr, ticks_ext;
  logic [CW:0]                 ticks_p1;
  logic                        active, wait_to, trig_end, waiting;
  logic [WAIT_COUNT_BITS-1:0]  ticks_inc;
  logic [PULSE_COUNT_BITS-1:0] pulse_inc;

  assign wmax      = CW'({WAIT_COUNT_BITS{1'b1}});
  assign to_ext    = CW'(cfg.timeout_ticks);
  assign tr_ext    = CW'(cfg.trigger_ticks);
  assign lim_to    = (to_ext > wmax) ? wmax : to_ext;
  assign lim_tr    = (tr_ext > wmax) ? wmax : ((tr_ext == '0) ? CW'(1) : tr_ext);
  assign ticks_ext = CW'(ticks_r);
  assign ticks_p1  = {1'b0, ticks_ext} + 1'b1;

  assign active    = (echo == cfg.active_level);
  assign wait_to   = (ticks_ext >= lim_to);
  assign trig_end  = (ticks_p1 >= {1'b0, lim_tr});
  assign waiting   = (phase_r == PH_LEAVE) || ((phase_r == PH_ARRIVE) && !active);
  assign ticks_inc = (ticks_r == '1) ? ticks_r : ticks_r + 1'b1;
  assign pulse_inc = (pulse_r == '1) ? pulse_r : pulse_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_TRIGGER: if (trig_end) phase_nxt = PH_LEAVE;
      PH_LEAVE: begin
        if (wait_to) phase_nxt = PH_TRIGGER;
        else if (!active) phase_nxt = PH_ARRIVE;
      end
      PH_ARRIVE: begin
        if (active) phase_nxt = PH_MEASURE;
        else if (wait_to) phase_nxt = PH_TRIGGER;
      end
      PH_MEASURE: if (!active) phase_nxt = PH_TRIGGER;
      default: phase_nxt = PH_TRIGGER;
    endcase
  end

  always_comb begin
    flags.trig = (phase_r == PH_TRIGGER);
    flags.tout = waiting && wait_to;
    flags.done = flags.tout || ((phase_r == PH_MEASURE) && !active);
    cnt        = ((phase_r == PH_MEASURE) && !active) ? pulse_r : '0;
  end

  always_comb begin
    ticks_nxt = ticks_r;
    pulse_nxt = pulse_r;
    unique case (phase_r)
      PH_TRIGGER: ticks_nxt = trig_end ? '0 : WAIT_COUNT_BITS'(ticks_p1);
      PH_LEAVE:   ticks_nxt = wait_to ? '0 : ticks_inc;
      PH_ARRIVE: begin
        if (active) pulse_nxt = PULSE_COUNT_BITS'(1);
        else        ticks_nxt = wait_to ? '0 : ticks_inc;
      end
      PH_MEASURE: begin
        if (active) pulse_nxt = pulse_inc;
        else begin
          ticks_nxt = '0;
          pulse_nxt = '0;
        end
      end
      default: ticks_nxt = '0;
    endcase
    if (flags.tout) pulse_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TRIGGER;
      ticks_r <= '0;
      pulse_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      pulse_r <= pulse_nxt;
    end
  end

endmodule

>>> hw/rtl/uer_queue.sv
// Short queue between the tick sequencer and the arithmetic pipeline.
// Depends on uer_pkg for its depth.
module uer_queue #(
  parameter int WIDTH = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  import uer_pkg::*;

  logic [WIDTH-1:0]  slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign full      = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/uer_back.sv
// Back end: converts a pulse count to microseconds and centimeters.
// Five registered stages ending in the output register; depends on uer_pkg.
module uer_back #(
  parameter int PULSE_COUNT_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        src_valid,
  input  uer_pkg::tick_flags_t        src_flags,
  input  logic [PULSE_COUNT_BITS-1:0] src_cnt,
  output logic                        src_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output uer_pkg::tick_flags_t        out_flags,
  output logic [17:0]                 out_us,
  output logic [11:0]                 out_cm
);
  import uer_pkg::*;

  localparam int XW  = PULSE_COUNT_BITS + 4;
  localparam int XW2 = (XW > X_SAT_W) ? XW : X_SAT_W;

  logic adv;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  tick_flags_t f1_r, f2_r, f3_r, f4_r, fo_r;

  logic [XW2-1:0] x;
  logic [21:0]    n1_r, n2_r;
  logic           sat1_r, sat2_r;
  logic [50:0]    p2;
  logic [18:0]    q2_r;
  logic [22:0]    r3;
  logic [17:0]    us3, us3_r, us4_r, us_o_r;
  logic [22:0]    m17;
  logic [19:0]    n4, n4_r;
  logic [45:0]    p4;
  logic [12:0]    q4_r, cm5;
  logic [20:0]    r5;
  logic [11:0]    cm_o_r;

  assign adv     = !out_v_r || out_ready;
  assign src_pop = adv && src_valid;

  assign x   = XW2'(src_cnt) * XW2'(MUL_TEN) + XW2'(ADD_ROUND);
  assign p2  = 51'(n1_r) * 51'(RECIP9);
  assign r3  = 23'(n2_r) - 23'(q2_r) * 23'(DIV9);
  assign us3 = sat2_r ? US_MAX : 18'(q2_r + ((r3 >= 23'(DIV9)) ? 19'd1 : 19'd0));
  assign m17 = 23'(us3_r) * 23'(MUL17);
  assign n4  = m17[22:3];
  assign p4  = 46'(n4) * 46'(RECIP125);
  assign r5  = 21'(n4_r) - 21'(q4_r) * 21'(DIV125);
  assign cm5 = q4_r + ((r5 >= 21'(DIV125)) ? 13'd1 : 13'd0);

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_r   <= x[24:3];
      sat1_r <= (x >= XW2'(X_SAT));
      f1_r   <= src_flags;
      n2_r   <= n1_r;
      sat2_r <= sat1_r;
      q2_r   <= p2[50:32];
      f2_r   <= f1_r;
      us3_r  <= us3;
      f3_r   <= f2_r;
      us4_r  <= us3_r;
      n4_r   <= n4;
      q4_r   <= p4[44:32];
      f4_r   <= f3_r;
      us_o_r <= us4_r;
      cm_o_r <= (cm5 > 13'(CM_MAX)) ? CM_MAX : cm5[11:0];
      fo_r   <= f4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= src_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_flags = fo_r;
  assign out_us    = us_o_r;
  assign out_cm    = cm_o_r;

endmodule

>>> hw/rtl/ultrasonic_echo_ranger_top.sv
// Ultrasonic echo ranger: one echo sample in, one result out, per transfer.
// Each input transfer is one tick; every tick yields exactly one result transfer.
// A new tick is taken every clock while the result side keeps up; results
// pass through the sequencer, the four-entry queue and five arithmetic
// stages ending in the output register. When the result side stalls,
// the queue absorbs up to four ticks before in_tready drops. Configuration
// writes take effect on the next accepted tick. Distance is only as fine as
// the sample tick; pulse_us = (count*10+16)/72 and distance_cm = us*17/1000.
// Depends on uer_pkg, uer_front, uer_queue and uer_back.
module ultrasonic_echo_ranger_top #(
  parameter int PULSE_COUNT_BITS = 20,
  parameter int WAIT_COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] echo_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] trigger_out, [18:1] pulse_us, [30:19] distance_cm
  output logic [1:0]  out_tuser,  // [0] done_res, [1] timed_out
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import uer_pkg::*;

  localparam int QW = $bits(tick_flags_t) + PULSE_COUNT_BITS;

  cfg_t                        cfg_r;
  logic                        in_fire, q_full, q_valid, q_pop;
  tick_flags_t                 f_flags, q_flags, o_flags;
  logic [PULSE_COUNT_BITS-1:0] f_cnt, q_cnt;
  logic [QW-1:0]               q_rd;
  logic [17:0]                 o_us;
  logic [11:0]                 o_cm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level  <= RST_ACTIVE_LEVEL;
      cfg_r.timeout_ticks <= RST_TIMEOUT_TICKS;
      cfg_r.trigger_ticks <= RST_TRIGGER_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ACTIVE_LEVEL:  cfg_r.active_level  <= cfg_wdata[0];
        CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_wdata;
        CFG_TRIGGER_TICKS: cfg_r.trigger_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  uer_front #(
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS),
    .WAIT_COUNT_BITS  (WAIT_COUNT_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (in_fire),
    .echo  (in_tdata[0]),
    .flags (f_flags),
    .cnt   (f_cnt)
  );

  uer_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data ({f_flags, f_cnt}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rd)
  );

  assign q_flags = q_rd[QW-1:PULSE_COUNT_BITS];
  assign q_cnt   = q_rd[PULSE_COUNT_BITS-1:0];

  uer_back #(
    .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (q_valid),
    .src_flags (q_flags),
    .src_cnt   (q_cnt),
    .src_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_flags (o_flags),
    .out_us    (o_us),
    .out_cm    (o_cm)
  );

  assign out_tdata = {1'b0, o_cm, o_us, o_flags.trig};
  assign out_tuser = {o_flags.tout, o_flags.done};

`ifndef SYNTHESIS
  a_tout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[30:1] == '0 && out_tuser[0])
    else $error("timeout result with nonzero measurement");

  a_trig_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tuser[0])
    else $error("trigger tick reported a finished measurement");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[30:1] == '0)
    else $error("nonzero range on a tick without a result");
`endif

endmodule

>>> tb/uer_range_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the ultrasonic echo ranger: tracks tick, result and register transfers.
// Predicts each result from the echo ticks and compares it with what the block returns.
// Depends on uer_pkg.
module uer_range_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] echo_level
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [0] trigger_out, [18:1] pulse_us, [30:19] distance_cm
  input  logic [1:0]  out_tuser,  // [0] done_res, [1] timed_out
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          readings_pending
);
  import uer_pkg::*;

  localparam int PULSE_BITS = 20;
  localparam int WAIT_BITS  = 16;

  typedef struct packed {
    logic        trig;
    logic        done;
    logic        tout;
    logic [17:0] us;
    logic [11:0] cm;
  } reading_t;

  cfg_t                  ranger_cfg;
  phase_t                ph;
  logic [WAIT_BITS-1:0]  wait_cnt;
  logic [PULSE_BITS-1:0] pulse_cnt;
  reading_t              readings_due[$];
  reading_t              want;
  reading_t              seen;
  int                    bad_count;

  function automatic logic wait_spent();
    if (wait_cnt >= ranger_cfg.timeout_ticks) return 1'b1;
    if (wait_cnt != '1) wait_cnt++;
    return 1'b0;
  endfunction

  function automatic reading_t sample_echo(input logic echo);
    reading_t    r;
    logic        active;
    logic [16:0] lim;
    logic [63:0] scaled;
    logic [63:0] us_v;
    logic [63:0] cm_v;
    r      = '0;
    active = (echo == ranger_cfg.active_level);
    case (ph) inside
      PH_TRIGGER: begin
        r.trig = 1'b1;
        lim = (ranger_cfg.trigger_ticks == '0) ? 17'd1 : {1'b0, ranger_cfg.trigger_ticks};
        if ({1'b0, wait_cnt} + 17'd1 >= lim) begin
          ph       = PH_LEAVE;
          wait_cnt = '0;
        end else begin
          wait_cnt++;
        end
      end
      PH_LEAVE, PH_ARRIVE: begin
        if (ph == PH_LEAVE && active) begin
          r.tout = wait_spent();
        end else if (!active) begin
          ph     = PH_ARRIVE;
          r.tout = wait_spent();
        end else begin
          ph        = PH_MEASURE;
          pulse_cnt = PULSE_BITS'(1);
        end
        r.done = r.tout;
      end
      default: begin
        if (active) begin
          if (pulse_cnt != '1) pulse_cnt++;
        end else begin
          r.done = 1'b1;
          scaled = 64'(pulse_cnt) * 64'd10 + 64'd16;
          us_v   = scaled / 64'd72;
          cm_v   = us_v * 64'd170 / 64'd10000;
          r.us   = (us_v > 64'(US_MAX)) ? US_MAX : us_v[17:0];
          r.cm   = (cm_v > 64'(CM_MAX)) ? CM_MAX : cm_v[11:0];
        end
      end
    endcase
    if (r.done) begin
      ph        = PH_TRIGGER;
      wait_cnt  = '0;
      pulse_cnt = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ranger_cfg.active_level  = RST_ACTIVE_LEVEL;
      ranger_cfg.timeout_ticks = RST_TIMEOUT_TICKS;
      ranger_cfg.trigger_ticks = RST_TRIGGER_TICKS;
      ph        = PH_TRIGGER;
      wait_cnt  = '0;
      pulse_cnt = '0;
      bad_count = 0;
      readings_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[0], out_tuser[0], out_tuser[1], out_tdata[18:1], out_tdata[30:19]};
        if (readings_due.size() == 0) begin
          if (bad_count < 10)
            $display("%0t: result transfer with none outstanding: ", $realtime,
                     "trig=%0b done=%0b tout=%0b us=%0d cm=%0d",
                     seen.trig, seen.done, seen.tout, seen.us, seen.cm);
          bad_count++;
        end else begin
          want = readings_due.pop_front();
          if (want !== seen) begin
            if (bad_count < 10)
              $display("%0t: mismatch ", $realtime,
                       "exp trig=%0b done=%0b tout=%0b us=%0d cm=%0d, ",
                       want.trig, want.done, want.tout, want.us, want.cm,
                       "got trig=%0b done=%0b tout=%0b us=%0d cm=%0d",
                       seen.trig, seen.done, seen.tout, seen.us, seen.cm);
            bad_count++;
          end
        end
      end
      if (in_tvalid && in_tready) readings_due.push_back(sample_echo(in_tdata[0]));
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ACTIVE_LEVEL:  ranger_cfg.active_level  = cfg_wdata[0];
          CFG_TIMEOUT_TICKS: ranger_cfg.timeout_ticks = cfg_wdata;
          CFG_TRIGGER_TICKS: ranger_cfg.trigger_ticks = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatches       <= bad_count;
    readings_pending <= readings_due.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the ultrasonic echo ranger: clock, reset, echo ticks and register writes.
// Depends on uer_pkg, ultrasonic_echo_ranger_top and uer_range_checker.
module tb;
  import uer_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [0] echo_level
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [0] trigger_out, [18:1] pulse_us, [30:19] distance_cm
  logic [1:0]  out_tuser;        // [0] done_res, [1] timed_out
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  int mismatches;
  int readings_pending;
  int cycle_count = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int rx_hold = 0;
  int rx_stall;
  bit rx_calm = 1'b0;
  bit calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ultrasonic_echo_ranger_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  uer_range_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .readings_pending (readings_pending)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int echo_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 12);
    if (r < 90) return $urandom_range(13, 60);
    return $urandom_range(61, 200);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
      hold_seen  <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      rx_hold    <= 400;
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_calm) begin
      out_tready <= 1'b1;
    end else begin
      rx_stall = idle_len();
      if (rx_stall > 0) begin
        rx_hold    <= rx_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_tick(input logic level);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_run(input logic level, input int n);
    for (int i = 0; i < n; i++) send_tick(level);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
  endtask

  task automatic program_ranger(input logic level, input logic [15:0] tmo,
                                input logic [15:0] trg);
    logic [15:0] level_word;
    level_word    = 16'($urandom);
    level_word[0] = level;
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ACTIVE_LEVEL;
    cfg_wdata <= level_word;
    @(posedge clk);
    cfg_addr  <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_addr  <= CFG_TRIGGER_TICKS;
    cfg_wdata <= trg;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input logic level, input logic [15:0] tmo,
                              input logic [15:0] trg, input int items, input bit squeeze);
    int   sent;
    int   len;
    bit   squeezed;
    logic lvl;
    calm = 1'b0;
    rx_calm <= 1'b0;
    program_ranger(level, tmo, trg);
    sent     = 0;
    squeezed = 1'b0;
    lvl      = $urandom_range(0, 1);
    while (sent < items) begin
      if ($urandom_range(0, 99) < 10) begin
        send_tick(~lvl);
        sent++;
      end else begin
        lvl = ~lvl;
        len = echo_run_len();
        if (len > items - sent) len = items - sent;
        send_run(lvl, len);
        sent += len;
      end
      if (squeeze && !squeezed && sent >= 60) begin
        hold_reqs <= hold_reqs + 1;
        squeezed = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) begin
        calm = !calm;
        rx_calm <= calm;
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero limits: one trigger tick, then timeout on the first wait tick
    program_ranger(1'b1, 16'd0, 16'd0);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    drain();

    // active-low echo: full measurement, arrival timeout, leave timeout
    program_ranger(1'b0, 16'd3, 16'd2);
    send_run(1'b1, 2);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 3);
    send_run(1'b1, 7);
    send_run(1'b0, 6);
    drain();

    random_phase(1'b1, 16'd20, 16'd4, 180, 1'b0);
    random_phase(1'b0, 16'd7, 16'd1, 180, 1'b1);
    random_phase(1'b1, RST_TIMEOUT_TICKS, RST_TRIGGER_TICKS, 180, 1'b0);
    random_phase(1'b0, 16'd1, 16'd3, 130, 1'b0);
    random_phase(1'b1, 16'd60, 16'd10, 130, 1'b0);

    // largest limits: trigger stays high for every tick sent
    calm = 1'b1;
    rx_calm <= 1'b1;
    program_ranger(1'b1, 16'hFFFF, 16'hFFFF);
    send_run(1'b1, 24);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && readings_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
